// ===== rtl/core/irt_pkg.sv =====
// Package for the interval reservation table: sizes, codes and payload types.
`default_nettype none
package irt_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int ROW_COUNT     = 1024;
    localparam int POS_BITS      = 16;

    localparam int IDX_BITS   = $clog2(TABLE_ENTRIES);
    localparam int COUNT_BITS = $clog2(TABLE_ENTRIES + 1);

    typedef logic [POS_BITS-1:0]   t_pos;
    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic {
        CMD_RESERVE = 1'b0,
        CMD_LOOKUP  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        STS_RESERVED  = 3'd0,
        STS_OVERLAP   = 3'd1,
        STS_FULL      = 3'd2,
        STS_FOUND     = 3'd3,
        STS_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        t_cmd        cmd;
        logic [9:0]  row_index;
        logic [15:0] start_seat;
        logic [15:0] end_seat;
        logic [15:0] owner_id;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] found_owner;
    } t_out_item;

    typedef struct packed {
        logic [9:0]  row;
        t_pos        start_pos;
        t_pos        end_pos;
        logic [15:0] owner;
    } t_entry;

endpackage
`default_nettype wire

// ===== rtl/core/interval_reservation_table_top.sv =====
// Interval reservation table top level: entry memory, scan sequencer and result register.
//
// Each request is a reserve or a lookup against an append-only table of up to
// TABLE_ENTRIES intervals kept in a memory with one write and one read port. A request
// is taken only while the sequencer is idle; it then reads the stored entries in
// insertion order, one per cycle through the memory's one read port unless the scan is
// held, and compares each against the request in one shared compare unit. A hit ends
// the scan early, and the next request can be taken in the cycle after the result is
// registered.
// The result register lets the next request start while a result still waits; the scan
// holds for as long as that waiting result stays stalled. No clearing pass is needed
// after reset: only entries below the fill count are ever read.
`default_nettype none
module interval_reservation_table_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire irt_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output irt_pkg::t_out_item     o_out_data
);
    import irt_pkg::*;

    t_entry    r_mem [TABLE_ENTRIES];

    t_state    r_state, n_state;
    t_in_item  r_req;
    logic      r_bad;
    t_count    r_n;
    t_count    r_idx;
    logic      r_dv;
    t_entry    r_rd_q;
    t_count    r_fill;
    logic      r_out_vld;
    t_out_item r_out;

    logic      accept;
    logic      freeze;
    logic      match;
    logic      hit;
    logic      done;
    logic      rd_en;
    logic      wr_en;
    logic      row_bad;
    t_pos      q_start;
    t_pos      q_end;
    t_entry    wr_entry;
    t_out_item res;

    assign q_start = r_req.start_seat[POS_BITS-1:0];
    assign q_end   = r_req.end_seat[POS_BITS-1:0];
    assign row_bad = 32'(i_in_data.row_index) >= 32'(ROW_COUNT);

    assign accept = i_in_valid && (r_state == ST_IDLE);
    assign freeze = r_out_vld && i_out_stall;

    // shared compare unit: one stored entry against the held request
    always_comb begin
        match = 1'b0;
        if (r_rd_q.row == r_req.row_index) begin
            if (r_req.cmd == CMD_RESERVE) begin
                match = !(r_rd_q.end_pos < q_start || r_rd_q.start_pos > q_end);
            end else begin
                match = (q_start >= r_rd_q.start_pos) && (q_start <= r_rd_q.end_pos);
            end
        end
    end

    assign hit   = r_dv && match;
    assign done  = (r_state == ST_SCAN) && !freeze && (hit || (!r_dv && r_idx == r_n));
    assign rd_en = (r_state == ST_SCAN) && !freeze && !hit && (r_idx != r_n);
    assign wr_en = done && !hit && (r_req.cmd == CMD_RESERVE) && !r_bad
                   && (r_fill != t_count'(TABLE_ENTRIES));

    always_comb begin
        res.status      = STS_NOT_FOUND;
        res.found_owner = '0;
        if (hit) begin
            if (r_req.cmd == CMD_RESERVE) begin
                res.status = STS_OVERLAP;
            end else begin
                res.status      = STS_FOUND;
                res.found_owner = r_rd_q.owner;
            end
        end else if (r_req.cmd == CMD_RESERVE) begin
            priority if (r_bad) begin
                res.status = STS_OVERLAP;
            end else if (r_fill == t_count'(TABLE_ENTRIES)) begin
                res.status = STS_FULL;
            end else begin
                res.status = STS_RESERVED;
            end
        end
    end

    assign wr_entry.row       = r_req.row_index;
    assign wr_entry.start_pos = q_start;
    assign wr_entry.end_pos   = q_end;
    assign wr_entry.owner     = r_req.owner_id;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_fill[IDX_BITS-1:0]] <= wr_entry;
        if (rd_en) r_rd_q <= r_mem[r_idx[IDX_BITS-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_dv      <= 1'b0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (wr_en) r_fill <= r_fill + t_count'(1);
            // hold the compare stage while the result slot is blocked
            if (!freeze) r_dv <= rd_en;
            if (accept) begin
                r_idx <= '0;
            end else if (rd_en) begin
                r_idx <= r_idx + t_count'(1);
            end
            if (done) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_data;
            r_bad <= row_bad;
            r_n   <= row_bad ? '0 : r_fill;
        end
        if (done) r_out <= res;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= t_count'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= r_n))
        else $error("scan index passed entry count");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_out_vld)
        else $error("finished scan left no result");

    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_fill == $past(r_fill) + t_count'(1)) && (r_state == ST_IDLE))
        else $error("store did not advance fill count");

    a_dv_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == ST_SCAN))
        else $error("read data pending outside scan");

endmodule
`default_nettype wire
